// ===== rtl/core/ffspd_pkg.sv =====
// Shared types, character codes and hex helpers for the form field splitter.
package ffspd_pkg;

  localparam logic [7:0] ChAmp   = 8'h26;
  localparam logic [7:0] ChPct   = 8'h25;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowF  = 8'h66;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpF   = 8'h46;
  localparam logic [3:0] HexTen  = 4'd10;

  localparam int unsigned MaxResults = 3;

  typedef enum logic [1:0] {
    PendNone  = 2'd0,
    PendPct   = 2'd1,
    PendDigit = 2'd2
  } pend_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic [7:0] field_index;
    logic       field_end;
    logic       form_end;
  } result_t;

  typedef struct packed {
    logic [1:0]                 cnt;
    result_t [MaxResults-1:0]   res;
  } batch_t;

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= ChZero) && (c <= ChNine)) ||
           ((c >= ChLowA) && (c <= ChLowF)) ||
           ((c >= ChUpA) && (c <= ChUpF));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if ((c >= ChZero) && (c <= ChNine)) begin
      v = c - ChZero;
    end else if ((c >= ChLowA) && (c <= ChLowF)) begin
      v = c - ChLowA + {4'd0, HexTen};
    end else if ((c >= ChUpA) && (c <= ChUpF)) begin
      v = c - ChUpA + {4'd0, HexTen};
    end
    return v[3:0];
  endfunction

endpackage

// ===== rtl/core/ffspd_in_reg.sv =====
// Input register stage that holds one accepted request until the decoder takes it.
module ffspd_in_reg
  import ffspd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_valid_i,
  output logic       s_ready_o,
  input  logic       mode_i,
  input  logic [7:0] byte_i,
  input  logic       take_i,
  output logic       valid_o,
  output logic       mode_o,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic       mode_q;
  logic [7:0] byte_q;
  logic       load;

  assign s_ready_o = !valid_q || take_i;
  assign load      = s_valid_i && s_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      mode_q <= mode_i;
      byte_q <= byte_i;
    end
  end

  assign valid_o = valid_q;
  assign mode_o  = mode_q;
  assign byte_o  = byte_q;

endmodule

// ===== rtl/core/ffspd_decode.sv =====
// Splitting and percent-decoding logic with the escape and field counter state.
module ffspd_decode
  import ffspd_pkg::*;
#(
  parameter int unsigned MAX_FIELDS = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       adv_i,
  input  logic       mode_i,
  input  logic [7:0] byte_i,
  output batch_t     batch_o
);

  localparam int unsigned IdxCap = ((MAX_FIELDS - 1) > 255) ? 255 : (MAX_FIELDS - 1);

  pend_e      pend_q, pend_d;
  logic [7:0] digit_q, digit_d;
  logic [7:0] field_q, field_d;

  function automatic result_t mk(input logic [7:0] b, input logic has, input logic [7:0] idx,
                                 input logic fe, input logic fm);
    result_t r;
    r.out_byte    = b;
    r.has_byte    = has;
    r.field_index = idx;
    r.field_end   = fe;
    r.form_end    = fm;
    return r;
  endfunction

  always_comb begin
    logic [1:0] n;
    logic       flush;
    n       = 2'd0;
    flush   = 1'b0;
    pend_d  = pend_q;
    digit_d = digit_q;
    field_d = field_q;
    batch_o.res = '0;

    if (mode_i || (byte_i == ChAmp)) begin
      flush = 1'b1;
    end else if ((pend_q == PendPct) && is_hex(byte_i)) begin
      pend_d  = PendDigit;
      digit_d = byte_i;
    end else if ((pend_q == PendDigit) && is_hex(byte_i)) begin
      batch_o.res[n] = mk({hex_val(digit_q), hex_val(byte_i)}, 1'b1, field_q, 1'b0, 1'b0);
      n       = n + 2'd1;
      pend_d  = PendNone;
      digit_d = 8'd0;
    end else begin
      flush = 1'b1;
    end

    if (flush) begin
      if ((pend_q == PendPct) || (pend_q == PendDigit)) begin
        batch_o.res[n] = mk(ChPct, 1'b1, field_q, 1'b0, 1'b0);
        n = n + 2'd1;
      end
      if (pend_q == PendDigit) begin
        batch_o.res[n] = mk(digit_q, 1'b1, field_q, 1'b0, 1'b0);
        n = n + 2'd1;
      end
      pend_d  = PendNone;
      digit_d = 8'd0;
      if (mode_i) begin
        batch_o.res[n] = mk(8'd0, 1'b0, field_q, 1'b1, 1'b1);
        n = n + 2'd1;
        field_d = 8'd0;
      end else if (byte_i == ChAmp) begin
        batch_o.res[n] = mk(8'd0, 1'b0, field_q, 1'b1, 1'b0);
        n = n + 2'd1;
        if (field_q < 8'(IdxCap)) begin
          field_d = field_q + 8'd1;
        end
      end else if (byte_i == ChPct) begin
        pend_d = PendPct;
      end else begin
        batch_o.res[n] = mk(byte_i, 1'b1, field_q, 1'b0, 1'b0);
        n = n + 2'd1;
      end
    end

    batch_o.cnt = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= PendNone;
      digit_q <= 8'd0;
      field_q <= 8'd0;
    end else if (adv_i) begin
      pend_q  <= pend_d;
      digit_q <= digit_d;
      field_q <= field_d;
    end
  end

endmodule

// ===== rtl/core/ffspd_out_buf.sv =====
// Result register that holds one request's results and hands them out one per cycle while the sink is ready.
module ffspd_out_buf
  import ffspd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  batch_t  batch_i,
  output logic    take_o,
  output logic    m_valid_o,
  input  logic    m_ready_i,
  output result_t m_res_o
);

  result_t [MaxResults-1:0] res_q;
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] rd_q, rd_d;
  logic       fire;

  assign m_valid_o = (rd_q != cnt_q);
  assign fire      = m_valid_o && m_ready_i;
  assign take_o    = (rd_q == cnt_q) || (((rd_q + 2'd1) == cnt_q) && m_ready_i);
  assign m_res_o   = res_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    rd_d  = rd_q;
    if (load_i) begin
      cnt_d = batch_i.cnt;
      rd_d  = 2'd0;
    end else if (fire) begin
      rd_d = rd_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      rd_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      rd_q  <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= batch_i.res;
    end
  end

endmodule

// ===== rtl/core/form_field_split_percent_decode.sv =====
// Top level of the form body field splitter with percent decoding.
// Each request carries one form byte or an end-of-form mark; the block splits the body into
// fields at '&' and turns '%' with two hex digits into one byte. A request is registered, then
// decoded into up to three results, which leave through a result register one per cycle
// while the sink is ready. An ordinary byte gives one result, and a new one is taken every
// cycle while the sink is ready; a request that closes a field behind a held escape, or
// breaks an escape, can give two or three results and holds the input meanwhile. Field-end
// results carry tlast, and field indices saturate at the smaller of MAX_FIELDS-1 and 255.
module form_field_split_percent_decode
  import ffspd_pkg::*;
#(
  parameter int unsigned MAX_FIELDS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic [0:0]  s_axis_tuser,   // [0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [15:8] field_index
  output logic        m_axis_tlast,   // field_end
  output logic [1:0]  m_axis_tuser    // [0] has_byte, [1] form_end
);

  logic       take;
  logic       in_valid;
  logic       in_mode;
  logic [7:0] in_byte;
  logic       adv;
  batch_t     batch;
  result_t    res;

  ffspd_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .mode_i    (s_axis_tuser[0]),
    .byte_i    (s_axis_tdata),
    .take_i    (take),
    .valid_o   (in_valid),
    .mode_o    (in_mode),
    .byte_o    (in_byte)
  );

  assign adv = in_valid && take;

  ffspd_decode #(
    .MAX_FIELDS (MAX_FIELDS)
  ) u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .mode_i  (in_mode),
    .byte_i  (in_byte),
    .batch_o (batch)
  );

  ffspd_out_buf u_out_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (adv),
    .batch_i   (batch),
    .take_o    (take),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_res_o   (res)
  );

  assign m_axis_tdata = {res.field_index, res.out_byte};
  assign m_axis_tlast = res.field_end;
  assign m_axis_tuser = {res.form_end, res.has_byte};

endmodule

// ===== tb/form_field_split_percent_decode_tb.sv =====
// Self-checking testbench for the form field splitter with percent decoding.
module form_field_split_percent_decode_tb;
  import ffspd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxFields = 256;
  localparam logic [7:0] IndexCap = (MaxFields - 1 > 255) ? 8'd255 : 8'(MaxFields - 1);
  localparam int unsigned RandItems = 460;
  localparam int unsigned StormFields = 262;
  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned TailCycles = 8;

  typedef struct packed {
    logic       mode;
    logic [7:0] data;
    logic       typed;
    result_t    res;
  } dir_row_t;

  localparam dir_row_t DirTab [24] = '{
    '{1'b1, 8'h00, 1'b1, '{8'h00, 1'b0, 8'h00, 1'b1, 1'b1}},
    '{1'b0, 8'hFF, 1'b1, '{8'hFF, 1'b1, 8'h00, 1'b0, 1'b0}},
    '{1'b0, 8'h01, 1'b1, '{8'h01, 1'b1, 8'h00, 1'b0, 1'b0}},
    '{1'b0, ChPct, 1'b0, '0},
    '{1'b0, 8'h66, 1'b0, '0},
    '{1'b0, 8'h46, 1'b0, '0},
    '{1'b0, ChPct, 1'b0, '0},
    '{1'b0, 8'h47, 1'b0, '0},
    '{1'b0, ChPct, 1'b0, '0},
    '{1'b0, 8'h61, 1'b0, '0},
    '{1'b0, 8'h7A, 1'b0, '0},
    '{1'b0, ChPct, 1'b0, '0},
    '{1'b0, ChPct, 1'b0, '0},
    '{1'b0, 8'h32, 1'b0, '0},
    '{1'b0, 8'h36, 1'b0, '0},
    '{1'b0, ChAmp, 1'b1, '{8'h00, 1'b0, 8'h00, 1'b1, 1'b0}},
    '{1'b0, ChPct, 1'b0, '0},
    '{1'b0, ChAmp, 1'b0, '0},
    '{1'b0, ChPct, 1'b0, '0},
    '{1'b0, 8'h42, 1'b0, '0},
    '{1'b0, ChAmp, 1'b0, '0},
    '{1'b0, ChPct, 1'b0, '0},
    '{1'b0, 8'h39, 1'b0, '0},
    '{1'b1, 8'hA5, 1'b0, '0}
  };

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic [0:0]  s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [1:0]  m_axis_tuser;

  result_t     field_results_due [$];
  pend_e       pend_state;
  logic [7:0]  held_digit;
  logic [7:0]  field_idx;
  int unsigned n_errors;
  int unsigned items_sent;
  int unsigned fields_closed;
  bit          src_calm;
  bit          sink_calm;
  int unsigned stall_left;
  int unsigned sink_cycles;
  int unsigned idle_cycles;

  form_field_split_percent_decode #(
    .MAX_FIELDS(MaxFields)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if ((c >= ChZero) && (c <= ChNine)) begin
      d = c - ChZero;
      return {1'b1, d[3:0]};
    end
    if ((c >= ChLowA) && (c <= ChLowF)) begin
      d = c - ChLowA + 8'd10;
      return {1'b1, d[3:0]};
    end
    if ((c >= ChUpA) && (c <= ChUpF)) begin
      d = c - ChUpA + 8'd10;
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 20);
  endfunction

  function automatic void emit(input logic [7:0] b, input logic has, input logic fe,
                               input logic fm, input bit keep);
    result_t r;
    r.out_byte    = b;
    r.has_byte    = has;
    r.field_index = field_idx;
    r.field_end   = fe;
    r.form_end    = fm;
    if (keep) field_results_due.push_back(r);
  endfunction

  function automatic void release_held(input bit keep);
    if (pend_state != PendNone) emit(ChPct, 1'b1, 1'b0, 1'b0, keep);
    if (pend_state == PendDigit) emit(held_digit, 1'b1, 1'b0, 1'b0, keep);
    pend_state = PendNone;
    held_digit = 8'h00;
  endfunction

  function automatic void split_decode(input logic mode, input logic [7:0] c, input bit keep);
    logic [4:0] lo;
    logic [4:0] hi;
    lo = hex_nibble(c);
    hi = hex_nibble(held_digit);
    if (mode) begin
      release_held(keep);
      emit(8'h00, 1'b0, 1'b1, 1'b1, keep);
      field_idx = 8'h00;
    end else if (c == ChAmp) begin
      release_held(keep);
      emit(8'h00, 1'b0, 1'b1, 1'b0, keep);
      if (field_idx < IndexCap) field_idx = field_idx + 8'd1;
    end else if ((pend_state == PendPct) && lo[4]) begin
      held_digit = c;
      pend_state = PendDigit;
    end else if ((pend_state == PendDigit) && lo[4]) begin
      emit({hi[3:0], lo[3:0]}, 1'b1, 1'b0, 1'b0, keep);
      pend_state = PendNone;
      held_digit = 8'h00;
    end else begin
      release_held(keep);
      if (c == ChPct) pend_state = PendPct;
      else emit(c, 1'b1, 1'b0, 1'b0, keep);
    end
  endfunction

  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (field_results_due.size() != 0);
  endtask

  task automatic send_item(input logic mode, input logic [7:0] data, input logic typed,
                           input result_t typed_res);
    int unsigned gap;
    if (items_sent % 40 == 0) src_calm = ($urandom_range(0, 3) == 0);
    gap = pick_gap(src_calm);
    if ($urandom_range(0, 99) < 2) hold_until_drained();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= data;
    do @(posedge clk_i); while (!s_axis_tready);
    split_decode(mode, data, !typed);
    if (typed) field_results_due.push_back(typed_res);
    items_sent++;
    if (!mode && data == ChAmp) fields_closed++;
  endtask

  function automatic logic [7:0] any_hex();
    int unsigned r;
    r = $urandom_range(0, 21);
    if (r < 10) return ChZero + 8'(r);
    if (r < 16) return ChLowA + 8'(r - 10);
    return ChUpA + 8'(r - 16);
  endfunction

  function automatic logic [7:0] non_hex();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (hex_nibble(c) != 5'd0);
    return c;
  endfunction

  task automatic send_byte(input logic [7:0] c);
    send_item(1'b0, c, 1'b0, '0);
  endtask

  task automatic send_token(input bit allow_eof);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      send_byte(8'($urandom_range(1, 255)));
    end else if (r < 45) begin
      send_byte(ChAmp);
    end else if (r < 65) begin
      send_byte(ChPct);
      send_byte(any_hex());
      send_byte(any_hex());
    end else if (r < 74) begin
      send_byte(ChPct);
      send_byte(non_hex());
    end else if (r < 83) begin
      send_byte(ChPct);
      send_byte(any_hex());
      send_byte(non_hex());
    end else if (r < 91) begin
      send_byte(ChPct);
      if ($urandom_range(0, 1) == 1) send_byte(any_hex());
    end else if (allow_eof) begin
      send_item(1'b1, 8'($urandom_range(0, 255)), 1'b0, '0);
    end else begin
      send_byte(8'($urandom_range(1, 255)));
    end
  endtask

  task automatic report_field(input string name, input int unsigned want,
                              input int unsigned got);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
    n_errors++;
  endtask

  task automatic check_result();
    result_t want;
    if (field_results_due.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %h/%b/%b", $realtime,
               m_axis_tdata, m_axis_tlast, m_axis_tuser);
      n_errors++;
    end else begin
      want = field_results_due.pop_front();
      if (want.out_byte != m_axis_tdata[7:0])
        report_field("out_byte", want.out_byte, m_axis_tdata[7:0]);
      if (want.has_byte != m_axis_tuser[0])
        report_field("has_byte", want.has_byte, m_axis_tuser[0]);
      if (want.field_index != m_axis_tdata[15:8])
        report_field("field_index", want.field_index, m_axis_tdata[15:8]);
      if (want.field_end != m_axis_tlast)
        report_field("field_end", want.field_end, m_axis_tlast);
      if (want.form_end != m_axis_tuser[1])
        report_field("form_end", want.form_end, m_axis_tuser[1]);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (sink_cycles % 50 == 0) sink_calm = ($urandom_range(0, 3) == 0);
      sink_cycles++;
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        stall_left = pick_gap(sink_calm);
      end
    end
  end

  initial begin
    idle_cycles = 0;
    wait (rst_ni);
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("form_field_split_percent_decode_tb: done, errors");
    $finish;
  end

  initial begin
    n_errors      = 0;
    items_sent    = 0;
    fields_closed = 0;
    src_calm      = 1'b0;
    sink_calm     = 1'b0;
    stall_left    = 0;
    sink_cycles   = 0;
    pend_state    = PendNone;
    held_digit    = 8'h00;
    field_idx     = 8'h00;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirTab[i]) send_item(DirTab[i].mode, DirTab[i].data, DirTab[i].typed, DirTab[i].res);

    hold_until_drained();
    items_sent    = 0;
    fields_closed = 0;
    while (fields_closed < StormFields) begin
      if ($urandom_range(0, 99) < 95) send_byte(ChAmp);
      else send_token(1'b0);
    end
    send_item(1'b1, 8'($urandom_range(0, 255)), 1'b0, '0);

    while (items_sent < RandItems) send_token(1'b1);
    send_item(1'b1, 8'($urandom_range(0, 255)), 1'b0, '0);

    hold_until_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("form_field_split_percent_decode_tb: done, clean");
    end else begin
      $display("form_field_split_percent_decode_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/ffspd_pkg.sv
rtl/core/ffspd_in_reg.sv
rtl/core/ffspd_decode.sv
rtl/core/ffspd_out_buf.sv
rtl/core/form_field_split_percent_decode.sv
tb/form_field_split_percent_decode_tb.sv
